// ----- sv/trilinear_grid_sampler_assert.svh -----
// Assertion macros shared by the trilinear grid sampler modules.
`ifndef TRILINEAR_GRID_SAMPLER_ASSERT_SVH
`define TRILINEAR_GRID_SAMPLER_ASSERT_SVH

// same-cycle implication
`define TGS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tgs_pkg.sv -----
// Shared constants and types of the trilinear grid sampler.
package tgs_pkg;

	localparam int X_BITS = 5;
	localparam int Y_BITS = 5;
	localparam int Z_BITS = 5;
	localparam int GRID_X = 1 << X_BITS;
	localparam int GRID_Y = 1 << Y_BITS;
	localparam int GRID_Z = 1 << Z_BITS;
	localparam int CELL_BITS = X_BITS + Y_BITS + Z_BITS;
	localparam int Q_BITS = (X_BITS > Y_BITS) ?
		((X_BITS > Z_BITS) ? X_BITS : Z_BITS) :
		((Y_BITS > Z_BITS) ? Y_BITS : Z_BITS);

	localparam int FRAC_BITS = 16;
	localparam int FRAC_W = FRAC_BITS + 1;
	localparam int LOC_STEPS = 1 + Q_BITS + FRAC_BITS;
	localparam int FRONT_LAT = LOC_STEPS + 1;

	localparam int BANKS = 8;
	localparam int BANK_AW = CELL_BITS - 3;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_PW = 2;
	localparam int OUT_DEPTH = 16;
	localparam int OUT_PW = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [31:0] OUTSIDE_VALUE = -32'sd655360;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_SPACING_X = 3'd3,
		REG_SPACING_Y = 3'd4,
		REG_SPACING_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [30:0] spacing_x;
		logic [30:0] spacing_y;
		logic [30:0] spacing_z;
	} cfg_t;

	typedef struct packed {
		logic is_query;
		logic oog;
		logic [X_BITS-1:0] cell_x;
		logic [Y_BITS-1:0] cell_y;
		logic [Z_BITS-1:0] cell_z;
		logic signed [FRAC_W-1:0] frac_x;
		logic signed [FRAC_W-1:0] frac_y;
		logic signed [FRAC_W-1:0] frac_z;
		logic ld_ok;
		logic [2:0] ld_bank;
		logic [BANK_AW-1:0] ld_addr;
		logic signed [31:0] ld_value;
	} mid_item_t;

endpackage

// ----- sv/tgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tgs_locate.sv -----
// One axis of the locator: cell index and Q.16 fraction by pipelined restoring division.
module tgs_locate (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [31:0]                    coord,
	input  logic signed [31:0]                    origin,
	input  logic [30:0]                           spacing,
	input  logic [tgs_pkg::Q_BITS-1:0]            axis_last,
	output logic [tgs_pkg::Q_BITS-1:0]            cell_idx,
	output logic signed [tgs_pkg::FRAC_W-1:0]     frac,
	output logic                                  oog
);

	typedef struct packed {
		logic neg;
		logic oog;
		logic [tgs_pkg::Q_BITS-1:0] q;
		logic [32:0] r;
		logic [tgs_pkg::FRAC_BITS-1:0] u;
	} loc_t;

	logic signed [32:0] diff_s1;
	loc_t loc_q [tgs_pkg::LOC_STEPS];
	loc_t head;
	loc_t last;
	logic [32:0] mag;
	logic [39:0] lim0;
	logic [tgs_pkg::FRAC_W-1:0] ext;

	function automatic loc_t step(loc_t cur, int j, logic [30:0] s,
		logic [tgs_pkg::Q_BITS-1:0] lastc);
		loc_t nxt;
		logic [39:0] lim;
		logic [32:0] m2;
		nxt = cur;
		lim = '0;
		m2 = '0;
		if (j <= tgs_pkg::Q_BITS) begin
			lim = 40'(s) << (tgs_pkg::Q_BITS - j);
			if ({7'b0, cur.r} >= lim) begin
				nxt.r = cur.r - lim[32:0];
				nxt.q[tgs_pkg::Q_BITS - j] = 1'b1;
			end
		end else begin
			if (j == tgs_pkg::Q_BITS + 1 && cur.q >= lastc) begin
				nxt.oog = 1'b1;
			end
			m2 = {cur.r[31:0], 1'b0};
			if (m2 >= {2'b0, s}) begin
				nxt.r = m2 - {2'b0, s};
				nxt.u = {cur.u[tgs_pkg::FRAC_BITS-2:0], 1'b1};
			end else begin
				nxt.r = m2;
				nxt.u = {cur.u[tgs_pkg::FRAC_BITS-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	// below the origin by less than one spacing the quotient steps all fail, so the cell stays 0
	always_comb begin
		mag = diff_s1[32] ? 33'(-diff_s1) : 33'(diff_s1);
		lim0 = diff_s1[32] ? 40'(spacing) : (40'(spacing) << tgs_pkg::Q_BITS);
		head.neg = diff_s1[32];
		head.oog = (spacing == '0) || ({7'b0, mag} >= lim0);
		head.q = '0;
		head.r = mag;
		head.u = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= 33'(coord) - 33'(origin);
			loc_q[0] <= head;
			for (int j = 1; j < tgs_pkg::LOC_STEPS; j++) begin
				loc_q[j] <= step(loc_q[j-1], j, spacing, axis_last);
			end
		end
	end

	// floor of a negative fraction
	always_comb begin
		last = loc_q[tgs_pkg::LOC_STEPS-1];
		ext = {1'b0, last.u};
		cell_idx = last.q;
		oog = last.oog;
		if (!last.neg) begin
			frac = signed'(ext);
		end else if (|last.r) begin
			frac = signed'(~ext);
		end else begin
			frac = signed'(-ext);
		end
	end

endmodule

// ----- sv/tgs_front.sv -----
// Front end: accepts items, locates query cells on three axes, queues them for the back end.
`include "trilinear_grid_sampler_assert.svh"

module tgs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       operation,
	input  logic [14:0]                grid_index,
	input  logic signed [31:0]         sample_value,
	input  logic signed [31:0]         coord_x,
	input  logic signed [31:0]         coord_y,
	input  logic signed [31:0]         coord_z,
	input  tgs_pkg::cfg_t              cfg,
	output logic                       mid_vld,
	output tgs_pkg::mid_item_t         mid_item,
	input  logic                       mid_take
);

	typedef struct packed {
		logic is_query;
		logic ld_ok;
		logic [2:0] ld_bank;
		logic [tgs_pkg::BANK_AW-1:0] ld_addr;
		logic signed [31:0] ld_value;
	} pay_t;

	logic adv;
	logic [tgs_pkg::FRONT_LAT-1:0] vld_q;
	pay_t pay_q [tgs_pkg::FRONT_LAT];
	pay_t entry;
	pay_t tail;
	logic [31:0] idx32;
	logic [tgs_pkg::X_BITS-1:0] ld_x;
	logic [tgs_pkg::Y_BITS-1:0] ld_y;
	logic [tgs_pkg::Z_BITS-1:0] ld_z;

	logic [tgs_pkg::Q_BITS-1:0] cx, cy, cz;
	logic signed [tgs_pkg::FRAC_W-1:0] fx, fy, fz;
	logic ox, oy, oz;

	tgs_pkg::mid_item_t mq_q [tgs_pkg::MQ_DEPTH];
	tgs_pkg::mid_item_t mq_in;
	logic [tgs_pkg::MQ_PW-1:0] mq_wp_q, mq_rp_q;
	logic [tgs_pkg::MQ_PW:0] mq_cnt_q;
	logic mq_full, mq_wr;

	assign mq_full = (mq_cnt_q == (tgs_pkg::MQ_PW+1)'(tgs_pkg::MQ_DEPTH));
	assign adv = !(vld_q[tgs_pkg::FRONT_LAT-1] && mq_full);
	assign full = !adv;
	assign mq_wr = adv && vld_q[tgs_pkg::FRONT_LAT-1];

	always_comb begin
		idx32 = 32'(grid_index);
		ld_z = idx32[0 +: tgs_pkg::Z_BITS];
		ld_y = idx32[tgs_pkg::Z_BITS +: tgs_pkg::Y_BITS];
		ld_x = idx32[tgs_pkg::Z_BITS + tgs_pkg::Y_BITS +: tgs_pkg::X_BITS];
		entry.is_query = (operation == tgs_pkg::OP_QUERY);
		entry.ld_ok = ((idx32 >> tgs_pkg::CELL_BITS) == '0);
		entry.ld_bank = {ld_x[0], ld_y[0], ld_z[0]};
		entry.ld_addr = {ld_x[tgs_pkg::X_BITS-1:1], ld_y[tgs_pkg::Y_BITS-1:1],
			ld_z[tgs_pkg::Z_BITS-1:1]};
		entry.ld_value = sample_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[tgs_pkg::FRONT_LAT-2:0], push};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[0] <= entry;
			for (int j = 1; j < tgs_pkg::FRONT_LAT; j++) begin
				pay_q[j] <= pay_q[j-1];
			end
		end
	end

	tgs_locate u_loc_x (
		.clk(clk), .en(adv), .coord(coord_x), .origin(cfg.origin_x),
		.spacing(cfg.spacing_x), .axis_last(tgs_pkg::Q_BITS'(tgs_pkg::GRID_X - 1)),
		.cell_idx(cx), .frac(fx), .oog(ox)
	);

	tgs_locate u_loc_y (
		.clk(clk), .en(adv), .coord(coord_y), .origin(cfg.origin_y),
		.spacing(cfg.spacing_y), .axis_last(tgs_pkg::Q_BITS'(tgs_pkg::GRID_Y - 1)),
		.cell_idx(cy), .frac(fy), .oog(oy)
	);

	tgs_locate u_loc_z (
		.clk(clk), .en(adv), .coord(coord_z), .origin(cfg.origin_z),
		.spacing(cfg.spacing_z), .axis_last(tgs_pkg::Q_BITS'(tgs_pkg::GRID_Z - 1)),
		.cell_idx(cz), .frac(fz), .oog(oz)
	);

	always_comb begin
		tail = pay_q[tgs_pkg::FRONT_LAT-1];
		mq_in.is_query = tail.is_query;
		mq_in.oog = ox || oy || oz;
		mq_in.cell_x = cx[tgs_pkg::X_BITS-1:0];
		mq_in.cell_y = cy[tgs_pkg::Y_BITS-1:0];
		mq_in.cell_z = cz[tgs_pkg::Z_BITS-1:0];
		mq_in.frac_x = fx;
		mq_in.frac_y = fy;
		mq_in.frac_z = fz;
		mq_in.ld_ok = tail.ld_ok;
		mq_in.ld_bank = tail.ld_bank;
		mq_in.ld_addr = tail.ld_addr;
		mq_in.ld_value = tail.ld_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wp_q <= '0;
			mq_rp_q <= '0;
			mq_cnt_q <= '0;
		end else begin
			if (mq_wr) begin
				mq_wp_q <= mq_wp_q + 1'b1;
			end
			if (mid_take) begin
				mq_rp_q <= mq_rp_q + 1'b1;
			end
			if (mq_wr && !mid_take) begin
				mq_cnt_q <= mq_cnt_q + 1'b1;
			end else if (!mq_wr && mid_take) begin
				mq_cnt_q <= mq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mq_wr) begin
			mq_q[mq_wp_q] <= mq_in;
		end
	end

	assign mid_vld = (mq_cnt_q != '0);
	assign mid_item = mq_q[mq_rp_q];

	`TGS_ASSERT_IMPL(a_take_has_item, clk, arst_n, mid_take, mid_vld, "take from empty queue")
	`TGS_ASSERT_NEXT(a_mq_grows, clk, arst_n, mq_wr && !mid_take, mq_cnt_q == $past(mq_cnt_q) + 1'b1, "queue count lost a transfer")

endmodule

// ----- sv/tgs_back.sv -----
// Back end: eight-bank grid memory, three lerp levels and the result queue.
`include "trilinear_grid_sampler_assert.svh"

module tgs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mid_vld,
	input  tgs_pkg::mid_item_t   mid_item,
	output logic                 mid_take,
	input  logic                 pop,
	output logic                 empty,
	output logic signed [31:0]   result_value,
	output logic                 out_of_grid
);

	typedef struct packed {
		logic oog;
		logic [2:0] par;
		logic signed [tgs_pkg::FRAC_W-1:0] tx;
		logic signed [tgs_pkg::FRAC_W-1:0] ty;
		logic signed [tgs_pkg::FRAC_W-1:0] tz;
	} meta_t;

	typedef struct packed {
		logic oog;
		logic signed [31:0] value;
	} res_t;

	logic take_q;
	logic pop_acc;
	logic [tgs_pkg::OUT_PW:0] rsv_q;

	logic [31:0] rd [tgs_pkg::BANKS];
	logic [9:1] vld_s;
	meta_t meta_s [1:9];

	logic signed [31:0] lo [4];
	logic signed [31:0] hi [4];
	logic signed [31:0] a_s2 [4];
	logic signed [32:0] d_s2 [4];
	logic signed [31:0] a_s3 [4];
	logic signed [49:0] p_s3 [4];
	logic signed [49:0] r1 [4];
	logic signed [33:0] i_s4 [4];
	logic signed [33:0] a_s5 [2];
	logic signed [34:0] d_s5 [2];
	logic signed [33:0] a_s6 [2];
	logic signed [51:0] p_s6 [2];
	logic signed [51:0] r2 [2];
	logic signed [35:0] w_s7 [2];
	logic signed [35:0] a_s8;
	logic signed [36:0] d_s8;
	logic signed [35:0] a_s9;
	logic signed [53:0] p_s9;
	logic signed [53:0] r3;
	logic signed [37:0] res;
	res_t res_in;

	res_t of_q [tgs_pkg::OUT_DEPTH];
	logic [tgs_pkg::OUT_PW-1:0] of_wp_q, of_rp_q;
	logic [tgs_pkg::OUT_PW:0] of_cnt_q;

	assign mid_take = mid_vld &&
		(!mid_item.is_query || rsv_q < (tgs_pkg::OUT_PW+1)'(tgs_pkg::OUT_DEPTH));
	assign take_q = mid_take && mid_item.is_query;
	assign empty = (of_cnt_q == '0);
	assign pop_acc = pop && !empty;

	for (genvar b = 0; b < tgs_pkg::BANKS; b++) begin : g_bank
		logic [tgs_pkg::X_BITS-1:0] xs;
		logic [tgs_pkg::Y_BITS-1:0] ys;
		logic [tgs_pkg::Z_BITS-1:0] zs;
		logic [tgs_pkg::BANK_AW-1:0] ra;
		logic we;
		assign xs = mid_item.cell_x +
			tgs_pkg::X_BITS'(((b >> 2) & 1) ^ int'(mid_item.cell_x[0]));
		assign ys = mid_item.cell_y +
			tgs_pkg::Y_BITS'(((b >> 1) & 1) ^ int'(mid_item.cell_y[0]));
		assign zs = mid_item.cell_z +
			tgs_pkg::Z_BITS'((b & 1) ^ int'(mid_item.cell_z[0]));
		assign ra = {xs[tgs_pkg::X_BITS-1:1], ys[tgs_pkg::Y_BITS-1:1],
			zs[tgs_pkg::Z_BITS-1:1]};
		assign we = mid_take && !mid_item.is_query && mid_item.ld_ok &&
			(mid_item.ld_bank == 3'(b));
		tgs_ram #(.WIDTH(32), .DEPTH(2**tgs_pkg::BANK_AW)) u_bank (
			.clk(clk), .we(we), .waddr(mid_item.ld_addr),
			.wdata(mid_item.ld_value), .raddr(ra), .rdata(rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[8:1], take_q};
		end
	end

	// corner {dy,dz} low/high along x picked from banks by cell parity
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lo[k] = signed'(rd[{meta_s[1].par[2], k[1] ^ meta_s[1].par[1],
				k[0] ^ meta_s[1].par[0]}]);
			hi[k] = signed'(rd[{~meta_s[1].par[2], k[1] ^ meta_s[1].par[1],
				k[0] ^ meta_s[1].par[0]}]);
		end
		for (int k = 0; k < 4; k++) begin
			r1[k] = p_s3[k] + 50'sd32768;
		end
		for (int z = 0; z < 2; z++) begin
			r2[z] = p_s6[z] + 52'sd32768;
		end
		r3 = p_s9 + 54'sd32768;
		res = 38'(a_s9) + signed'(r3[53:16]);
		if (meta_s[9].oog) begin
			res_in.value = tgs_pkg::OUTSIDE_VALUE;
		end else if (res > 38'sd2147483647) begin
			res_in.value = 32'sh7fffffff;
		end else if (res < -38'sd2147483648) begin
			res_in.value = 32'sh80000000;
		end else begin
			res_in.value = res[31:0];
		end
		res_in.oog = meta_s[9].oog;
	end

	always_ff @(posedge clk) begin
		meta_s[1] <= {mid_item.oog,
			{mid_item.cell_x[0], mid_item.cell_y[0], mid_item.cell_z[0]},
			mid_item.frac_x, mid_item.frac_y, mid_item.frac_z};
		for (int n = 2; n <= 9; n++) begin
			meta_s[n] <= meta_s[n-1];
		end
		for (int k = 0; k < 4; k++) begin
			a_s2[k] <= lo[k];
			d_s2[k] <= 33'(hi[k]) - 33'(lo[k]);
			a_s3[k] <= a_s2[k];
			p_s3[k] <= d_s2[k] * meta_s[2].tx;
			i_s4[k] <= 34'(a_s3[k]) + signed'(r1[k][49:16]);
		end
		for (int z = 0; z < 2; z++) begin
			a_s5[z] <= i_s4[z];
			d_s5[z] <= 35'(i_s4[2+z]) - 35'(i_s4[z]);
			a_s6[z] <= a_s5[z];
			p_s6[z] <= d_s5[z] * meta_s[5].ty;
			w_s7[z] <= 36'(a_s6[z]) + signed'(r2[z][51:16]);
		end
		a_s8 <= w_s7[0];
		d_s8 <= 37'(w_s7[1]) - 37'(w_s7[0]);
		a_s9 <= a_s8;
		p_s9 <= d_s8 * meta_s[8].tz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wp_q <= '0;
			of_rp_q <= '0;
			of_cnt_q <= '0;
			rsv_q <= '0;
		end else begin
			if (vld_s[9]) begin
				of_wp_q <= of_wp_q + 1'b1;
			end
			if (pop_acc) begin
				of_rp_q <= of_rp_q + 1'b1;
			end
			if (vld_s[9] && !pop_acc) begin
				of_cnt_q <= of_cnt_q + 1'b1;
			end else if (!vld_s[9] && pop_acc) begin
				of_cnt_q <= of_cnt_q - 1'b1;
			end
			if (take_q && !pop_acc) begin
				rsv_q <= rsv_q + 1'b1;
			end else if (!take_q && pop_acc) begin
				rsv_q <= rsv_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[9]) begin
			of_q[of_wp_q] <= res_in;
		end
	end

	assign result_value = of_q[of_rp_q].value;
	assign out_of_grid = of_q[of_rp_q].oog;

	`TGS_ASSERT_IMPL(a_rsv_covers, clk, arst_n, 1'b1, rsv_q >= of_cnt_q, "reservation below queue fill")
	`TGS_ASSERT_IMPL(a_push_room, clk, arst_n, vld_s[9], of_cnt_q < (tgs_pkg::OUT_PW+1)'(tgs_pkg::OUT_DEPTH), "result queue overflow")
	`TGS_ASSERT_NEXT(a_rsv_step, clk, arst_n, take_q && !pop_acc, rsv_q == $past(rsv_q) + 1'b1, "reservation missed a query")

endmodule

// ----- sv/trilinear_grid_sampler.sv -----
// Top level: configuration registers, front locator and back interpolator.
// Path from push to result: a 23-stage division pipeline in the locator, the
// middle queue, the RAM read and the lerp stages.
// Throughput: one load or query per cycle while full is low; loads give no result.
// Reset clears all control state and sets origin 0, spacing 1.0 on each axis;
// the grid memory is not cleared and holds no valid data until loaded.
module trilinear_grid_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [14:0]        grid_index,
	input  logic signed [31:0] sample_value,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] result_value,
	output logic               out_of_grid,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	tgs_pkg::cfg_t cfg_q;
	tgs_pkg::mid_item_t mid_item;
	logic mid_vld;
	logic mid_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.spacing_x <= 31'd65536;
			cfg_q.spacing_y <= 31'd65536;
			cfg_q.spacing_z <= 31'd65536;
		end else if (cfg_write) begin
			case (cfg_index)
				tgs_pkg::REG_ORIGIN_X: cfg_q.origin_x <= signed'(cfg_data);
				tgs_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= signed'(cfg_data);
				tgs_pkg::REG_ORIGIN_Z: cfg_q.origin_z <= signed'(cfg_data);
				tgs_pkg::REG_SPACING_X: cfg_q.spacing_x <= cfg_data[30:0];
				tgs_pkg::REG_SPACING_Y: cfg_q.spacing_y <= cfg_data[30:0];
				tgs_pkg::REG_SPACING_Z: cfg_q.spacing_z <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	tgs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .grid_index(grid_index), .sample_value(sample_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .cfg(cfg_q),
		.mid_vld(mid_vld), .mid_item(mid_item), .mid_take(mid_take)
	);

	tgs_back u_back (
		.clk(clk), .arst_n(arst_n), .mid_vld(mid_vld), .mid_item(mid_item),
		.mid_take(mid_take), .pop(pop), .empty(empty),
		.result_value(result_value), .out_of_grid(out_of_grid)
	);

endmodule
